// ===== rtl/core/bba_pkg.sv =====
// package for the buddy block allocator: op kinds, status codes, register addresses, sequencer states
`timescale 1ns / 1ps
package bba_pkg;

	localparam int ARENA_BITS = 16;
	localparam int MIN_CLASS  = 6;
	localparam int MAX_CLASS  = 16;

	localparam logic [1:0] KIND_ALLOC  = 2'd0;
	localparam logic [1:0] KIND_FREE   = 2'd1;
	localparam logic [1:0] KIND_FORMAT = 2'd2;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_TOO_LARGE = 2'd1;
	localparam logic [1:0] ST_NO_SPACE  = 2'd2;

	localparam logic [1:0] REG_SEGMENT      = 2'd0;
	localparam logic [1:0] REG_ARENA_HEADER = 2'd1;
	localparam logic [1:0] REG_BLOCK_HEADER = 2'd2;

	typedef enum logic [4:0] {
		S_IDLE,
		S_CLEAR,
		S_FMT,
		S_AFIND,
		S_SPLIT,
		S_FREE_RD,
		S_FREE_CHK,
		S_MERGE,
		S_UL_RD,
		S_UL_WR,
		S_PS_RD,
		S_PS_WR,
		S_DONE
	} state_t;

	// what to do after an unlink or a push finishes
	typedef enum logic [2:0] {
		R_SPLIT_LO,
		R_SPLIT_HI,
		R_ALLOC_END,
		R_MERGE,
		R_FREE_END,
		R_FMT
	} ret_t;

endpackage

// ===== rtl/core/buddy_block_allocator_core.sv =====
// top level of the buddy block allocator: sequencer around per-unit memories
// channels: s_axis (op word in), m_axis (result word out), cfg (register writes)
// s_axis_tuser: kind[1:0]
// s_axis_tdata: request_bytes[15:0], user_offset_in[31:16]
// m_axis_tdata: status[1:0], user_offset[17:2], zero to 24 bits
// one op at a time; an op is taken only while the sequencer is idle
// an alloc picks the smallest nonempty class that fits and splits it down level
// by level; a free checks the block head, then merges with its buddy level by
// level; a bad free or an unknown kind only returns a result word; a format
// clears the unit flags, then lays out blocks, shrinking each to fit the segment
// every list change goes through the link memories, whose read data is registered
// after reset a clearing pass zeroes the unit flags with all ready low; no blocks
// exist until a format op
// the result sits in an output register; a stalled receiver holds the block in
// S_DONE and no new op is taken until the word leaves
// cfg: cfg_addr picks the register in the order segment, arena header, block header
`timescale 1ns / 1ps
module buddy_block_allocator_core
	import bba_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [1:0]  s_axis_tuser,  // kind
	input  logic [31:0] s_axis_tdata,  // request_bytes, user_offset_in
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // status, user_offset
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_addr,
	input  logic [16:0] cfg_data
);
	localparam int UB = ARENA_BITS - MIN_CLASS;   // unit index bits
	localparam int UNITS = 1 << UB;
	localparam int NCLASS = MAX_CLASS + 1;
	localparam int CB = 5;
	localparam int AW = ARENA_BITS + 2;           // byte offsets with headroom
	localparam logic [AW-1:0] ARENA_SIZE = AW'(1) << ARENA_BITS;
	localparam logic [AW-1:0] MIN_SIZE = AW'(1) << MIN_CLASS;

	typedef logic [UB-1:0] unit_t;

	// configuration registers
	logic [16:0] seg_q;
	logic [14:0] ahdr_q;
	logic [5:0]  bhdr_q;

	// memories
	logic [CB-1:0] cls_mem  [UNITS];
	unit_t         next_mem [UNITS];
	unit_t         prev_mem [UNITS];
	logic          fh_mem   [UNITS];
	logic          ah_mem   [UNITS];
	unit_t         head_q [NCLASS];
	logic [NCLASS-1:0] ne_q;

	state_t st_q, st_d;
	ret_t   ret_q;
	logic        init_q;               // clearing pass after reset
	logic [15:0] req_q, uin_q;
	logic [1:0]  status_q;
	logic [15:0] uoff_q;
	logic [CB-1:0] c_q, k_q;          // target class, working class
	unit_t u_q;                       // working block
	unit_t x_q;                       // unlink / push element
	logic [CB-1:0] xc_q;
	logic [AW-1:0] off_q;             // byte offset for format and merge
	logic [AW-1:0] seg_eff;
	logic [1:0] phase_q;
	unit_t nb_q, pv_q, tl_q;

	assign seg_eff = ({1'b0, seg_q} > ARENA_SIZE) ? ARENA_SIZE : AW'(seg_q);

	assign s_axis_tready = (st_q == S_IDLE);
	assign cfg_ready     = (st_q == S_IDLE);
	assign m_axis_tvalid = (st_q == S_DONE);
	assign m_axis_tdata  = {6'd0, uoff_q, status_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_q  <= 17'd65536;
			ahdr_q <= 15'd256;
			bhdr_q <= 6'd8;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_addr)
				REG_SEGMENT:      seg_q  <= cfg_data;
				REG_ARENA_HEADER: ahdr_q <= cfg_data[14:0];
				REG_BLOCK_HEADER: bhdr_q <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	// helpers
	function automatic logic [CB-1:0] bitlen(input logic [AW-1:0] v);
		logic [CB-1:0] n;
		n = '0;
		for (int i = 0; i < AW; i++) if (v[i]) n = CB'(i + 1);
		return n;
	endfunction

	function automatic logic [CB-1:0] lowz(input logic [AW-1:0] v);
		logic [CB-1:0] n;
		n = '0;
		for (int i = AW - 1; i >= 0; i--) if (v[i]) n = CB'(i);
		return n;
	endfunction

	// combinational values
	logic [AW-1:0] total, csize, buddy, fmt_first, uoff_ext, foff;
	logic [CB-1:0] ac;
	unit_t hi_u, rd_u;
	logic [CB-1:0] rd_cls;
	unit_t rd_next, rd_prev;
	logic rd_fh, rd_ah;
	logic [NCLASS-1:0] higher;

	assign total = AW'(req_q) + AW'(bhdr_q);
	always_comb begin
		ac = (total == '0) ? CB'(0) : bitlen(total - AW'(1));
		if (ac < CB'(MIN_CLASS)) ac = CB'(MIN_CLASS);
	end
	assign csize    = AW'(1) << k_q;
	assign buddy    = off_q ^ csize;
	assign fmt_first = AW'(1) << (bitlen(AW'(ahdr_q)) + CB'(1));
	assign uoff_ext = AW'(uin_q);
	assign foff     = uoff_ext - AW'(bhdr_q);
	assign hi_u     = unit_t'(u_q + (unit_t'(1) << (k_q - CB'(MIN_CLASS))));
	always_comb for (int i = 0; i < NCLASS; i++) higher[i] = ne_q[i] && (CB'(i) >= c_q);

	// read port: registered read data at address rd_u
	always_ff @(posedge clk) begin
		rd_cls  <= cls_mem[rd_u];
		rd_next <= next_mem[rd_u];
		rd_prev <= prev_mem[rd_u];
		rd_fh   <= fh_mem[rd_u];
		rd_ah   <= ah_mem[rd_u];
	end

	// next state for the idle and done states
	always_comb begin
		st_d = st_q;
		case (st_q)
			S_IDLE:   if (s_axis_tvalid) st_d = S_DONE;
			S_DONE:   if (m_axis_tready) st_d = S_IDLE;
			default:  ;
		endcase
	end

	// main sequencer: state, datapath and memory writes in one clocked process
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_CLEAR;
			init_q <= 1'b1;
			u_q <= '0;
			ne_q <= '0;
			phase_q <= '0;
			ret_q <= R_FMT;
		end else begin
			case (st_q)
				S_IDLE: begin
					if (s_axis_tvalid) begin
						req_q  <= s_axis_tdata[15:0];
						uin_q  <= s_axis_tdata[31:16];
						status_q <= ST_OK;
						uoff_q <= '0;
						phase_q <= '0;
						case (s_axis_tuser)
							KIND_ALLOC:  st_q <= S_AFIND;
							KIND_FREE:   st_q <= S_FREE_RD;
							KIND_FORMAT: begin
								st_q <= S_CLEAR;
								u_q  <= '0;
							end
							default:     st_q <= st_d;
						endcase
					end
				end
				S_CLEAR: begin
					fh_mem[u_q] <= 1'b0;
					ah_mem[u_q] <= 1'b0;
					ne_q <= '0;
					u_q <= u_q + unit_t'(1);
					if (u_q == unit_t'(UNITS - 1)) begin
						if (init_q) begin
							init_q <= 1'b0;
							st_q <= S_IDLE;
						end else begin
							st_q  <= S_FMT;
							off_q <= (fmt_first < MIN_SIZE) ? MIN_SIZE : fmt_first;
							phase_q <= '0;
						end
					end
				end
				S_FMT: begin
					// phase 0: pick class, phase 1: shrink to fit, then push the block
					if (phase_q == 2'd0) begin
						if (off_q + MIN_SIZE > seg_eff) st_q <= S_DONE;
						else begin
							k_q <= (lowz(off_q) > CB'(MAX_CLASS)) ? CB'(MAX_CLASS) : lowz(off_q);
							phase_q <= 2'd1;
						end
					end else begin
						if (off_q + csize > seg_eff) begin
							if (k_q == CB'(MIN_CLASS)) st_q <= S_DONE;
							else k_q <= k_q - CB'(1);
						end else begin
							x_q  <= unit_t'(off_q >> MIN_CLASS);
							xc_q <= k_q;
							off_q <= off_q + csize;
							ret_q <= R_FMT;
							phase_q <= 2'd0;
							st_q <= S_PS_RD;
						end
					end
				end
				S_AFIND: begin
					if (phase_q == 2'd0) begin
						c_q <= ac;
						phase_q <= 2'd1;
					end else if (c_q > CB'(MAX_CLASS)) begin
						status_q <= ST_TOO_LARGE;
						st_q <= S_DONE;
					end else if (higher == '0) begin
						status_q <= ST_NO_SPACE;
						st_q <= S_DONE;
					end else begin
						k_q <= lowz(AW'(higher));
						phase_q <= '0;
						st_q <= S_SPLIT;
					end
				end
				S_SPLIT: begin
					u_q <= head_q[k_q];
					x_q <= head_q[k_q];
					ret_q <= (k_q == c_q) ? R_ALLOC_END : R_SPLIT_LO;
					st_q <= S_UL_RD;
				end
				S_FREE_RD: begin
					u_q <= unit_t'(foff >> MIN_CLASS);
					off_q <= foff;
					if (uoff_ext < AW'(bhdr_q) || foff[MIN_CLASS-1:0] != '0 ||
						(foff >> MIN_CLASS) >= AW'(UNITS))
						st_q <= S_DONE;
					else st_q <= S_FREE_CHK;
					phase_q <= '0;
				end
				S_FREE_CHK: begin
					if (phase_q == 2'd0) phase_q <= 2'd1;    // read in flight
					else if (!rd_ah) st_q <= S_DONE;
					else begin
						ah_mem[u_q] <= 1'b0;
						k_q <= rd_cls;
						phase_q <= '0;
						st_q <= S_MERGE;
					end
				end
				S_MERGE: begin
					if (phase_q == 2'd0) begin
						if (k_q >= CB'(MAX_CLASS) || buddy < AW'(ahdr_q) ||
							buddy + csize > seg_eff || (buddy >> MIN_CLASS) >= AW'(UNITS)) begin
							x_q <= unit_t'(off_q >> MIN_CLASS);
							xc_q <= k_q;
							ret_q <= R_FREE_END;
							st_q <= S_PS_RD;
						end else begin
							u_q <= unit_t'(buddy >> MIN_CLASS);
							phase_q <= 2'd1;
						end
					end else if (phase_q == 2'd1) phase_q <= 2'd2;
					else begin
						if (!rd_fh || rd_cls != k_q) begin
							x_q <= unit_t'(off_q >> MIN_CLASS);
							xc_q <= k_q;
							ret_q <= R_FREE_END;
							st_q <= S_PS_RD;
						end else begin
							x_q <= u_q;
							ret_q <= R_MERGE;
							st_q <= S_UL_RD;
						end
						phase_q <= '0;
					end
				end
				// unlink x_q from list of its class, clear its free flag
				S_UL_RD: begin
					if (phase_q == 2'd0) phase_q <= 2'd1;
					else begin
						xc_q <= rd_cls;
						nb_q <= rd_next;
						pv_q <= rd_prev;
						phase_q <= '0;
						st_q <= S_UL_WR;
					end
				end
				S_UL_WR: begin
					fh_mem[x_q] <= 1'b0;
					if (xc_q <= CB'(MAX_CLASS)) begin
						if (nb_q == x_q) ne_q[xc_q] <= 1'b0;
						else begin
							next_mem[pv_q] <= nb_q;
							prev_mem[nb_q] <= pv_q;
							if (head_q[xc_q] == x_q) head_q[xc_q] <= nb_q;
						end
					end
					case (ret_q)
						R_SPLIT_LO: begin
							k_q <= k_q - CB'(1);
							x_q <= u_q;
							xc_q <= k_q - CB'(1);
							st_q <= S_PS_RD;
						end
						R_ALLOC_END: begin
							ah_mem[x_q] <= 1'b1;
							uoff_q <= 16'(({{(AW-UB){1'b0}}, x_q} << MIN_CLASS) + AW'(bhdr_q));
							st_q <= S_DONE;
						end
						R_MERGE: begin
							k_q <= k_q + CB'(1);
							off_q <= off_q & ~((AW'(1) << (k_q + CB'(1))) - AW'(1));
							st_q <= S_MERGE;
						end
						default: st_q <= S_DONE;
					endcase
				end
				// make_free(x_q, xc_q): mark and push to front of list
				S_PS_RD: begin
					cls_mem[x_q] <= xc_q;
					fh_mem[x_q] <= 1'b1;
					ah_mem[x_q] <= 1'b0;
					if (phase_q == 2'd0) phase_q <= 2'd1;       // address head
					else if (phase_q == 2'd1) phase_q <= 2'd2;  // data in flight
					else begin
						tl_q <= rd_prev;
						phase_q <= '0;
						st_q <= S_PS_WR;
					end
				end
				S_PS_WR: begin
					if (!ne_q[xc_q]) begin
						next_mem[x_q] <= x_q;
						prev_mem[x_q] <= x_q;
						ne_q[xc_q] <= 1'b1;
					end else begin
						next_mem[x_q] <= head_q[xc_q];
						prev_mem[x_q] <= tl_q;
						next_mem[tl_q] <= x_q;
						prev_mem[head_q[xc_q]] <= x_q;
					end
					head_q[xc_q] <= x_q;
					case (ret_q)
						R_SPLIT_LO: begin
							ret_q <= R_SPLIT_HI;
							x_q <= hi_u;
							st_q <= S_PS_RD;
						end
						R_SPLIT_HI: st_q <= S_SPLIT;
						R_FMT:      st_q <= S_FMT;
						default:    st_q <= S_DONE;
					endcase
				end
				S_DONE: st_q <= st_d;
				default: st_q <= S_IDLE;
			endcase
		end
	end

	// read address selection
	always_comb begin
		case (st_q)
			S_PS_RD: rd_u = head_q[xc_q];
			S_UL_RD: rd_u = x_q;
			default: rd_u = u_q;
		endcase
	end

endmodule

// ===== tb/sv/buddy_block_allocator_core_test.sv =====
// testbench for the buddy block allocator core: directed table, then random ops checked by a predictor
`timescale 1ns / 1ps
module buddy_block_allocator_core_test;
	import bba_pkg::*;

	localparam int UNITS = 1024;
	localparam int MINC = 6;
	localparam int MAXC = 16;
	localparam int STALL_LIMIT = 40000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [1:0]  s_axis_tuser = '0;   // kind
	logic [31:0] s_axis_tdata = '0;   // request_bytes, user_offset_in
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;        // status, user_offset
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_addr = '0;
	logic [16:0] cfg_data = '0;

	buddy_block_allocator_core dut (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// shadow of the allocator state and its registers
	bit [4:0]  unit_cls [UNITS];
	bit        free_head [UNITS];
	bit        busy_head [UNITS];
	bit [9:0]  next_link [UNITS];
	bit [9:0]  prev_link [UNITS];
	bit [9:0]  list_head [MAXC+1];
	bit [16:0] list_live;
	bit [16:0] seg_bytes = 17'd65536;
	bit [14:0] arena_hdr = 15'd256;
	bit [5:0]  block_hdr = 6'd8;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] offset;
	} result_t;

	result_t     pending_results[$];
	logic [15:0] live_blocks[$];
	logic [15:0] last_block;
	int          mismatches;
	bit          calm;
	int          quiet_cycles;

	function automatic int bit_length(longint unsigned v);
		int n;
		n = 0;
		while (v != 0) begin
			n++;
			v >>= 1;
		end
		return n;
	endfunction

	function automatic int trailing_zeros(longint unsigned v);
		int n;
		n = 0;
		if (v == 0) return 0;
		while (v[0] == 1'b0) begin
			n++;
			v >>= 1;
		end
		return n;
	endfunction

	function automatic longint unsigned usable_segment();
		return (seg_bytes > 17'd65536) ? 65536 : seg_bytes;
	endfunction

	function automatic void push_free_list(int c, bit [9:0] u);
		bit [9:0] h;
		bit [9:0] t;
		if (!list_live[c]) begin
			next_link[u] = u;
			prev_link[u] = u;
			list_live[c] = 1'b1;
		end else begin
			h = list_head[c];
			t = prev_link[h];
			next_link[u] = h;
			prev_link[u] = t;
			next_link[t] = u;
			prev_link[h] = u;
		end
		list_head[c] = u;
	endfunction

	function automatic void unlink_free(bit [9:0] u);
		int c;
		bit [9:0] n;
		bit [9:0] p;
		c = unit_cls[u];
		n = next_link[u];
		p = prev_link[u];
		if (n == u) begin
			list_live[c] = 1'b0;
			return;
		end
		next_link[p] = n;
		prev_link[n] = p;
		if (list_head[c] == u) list_head[c] = n;
	endfunction

	function automatic void release_block(bit [9:0] u, int c);
		unit_cls[u] = c[4:0];
		free_head[u] = 1'b1;
		busy_head[u] = 1'b0;
		push_free_list(c, u);
	endfunction

	function automatic void lay_out_arena();
		longint unsigned seg;
		longint unsigned off;
		int c;
		seg = usable_segment();
		off = longint'(1) << (bit_length(arena_hdr) + 1);
		for (int i = 0; i < UNITS; i++) begin
			free_head[i] = 1'b0;
			busy_head[i] = 1'b0;
		end
		list_live = '0;
		if (off < 64) off = 64;
		while (off + 64 <= seg) begin
			c = trailing_zeros(off);
			if (c > MAXC) c = MAXC;
			while (c >= MINC && off + (longint'(1) << c) > seg) c--;
			if (c < MINC) break;
			release_block(10'(off >> MINC), c);
			off += longint'(1) << c;
		end
	endfunction

	function automatic result_t carve_block(logic [15:0] req);
		result_t r;
		longint unsigned total;
		int c;
		int k;
		bit [9:0] u;
		bit [9:0] hi;
		r = '0;
		total = req + block_hdr;
		c = (total != 0) ? bit_length(total - 1) : 0;
		if (c < MINC) c = MINC;
		if (c > MAXC) begin
			r.status = ST_TOO_LARGE;
			return r;
		end
		k = c;
		while (k <= MAXC && !list_live[k]) k++;
		if (k > MAXC) begin
			r.status = ST_NO_SPACE;
			return r;
		end
		while (k > c) begin
			u = list_head[k];
			unlink_free(u);
			free_head[u] = 1'b0;
			k--;
			hi = u + (10'd1 << (k - MINC));
			release_block(u, k);
			release_block(hi, k);
		end
		u = list_head[c];
		unlink_free(u);
		free_head[u] = 1'b0;
		busy_head[u] = 1'b1;
		r.status = ST_OK;
		r.offset = 16'((longint'(u) << MINC) + block_hdr);
		return r;
	endfunction

	function automatic void return_block(logic [15:0] uoff);
		longint unsigned seg;
		longint unsigned off;
		longint unsigned size;
		longint unsigned b;
		bit [9:0] u;
		bit [9:0] bu;
		int c;
		seg = usable_segment();
		if (uoff < block_hdr) return;
		off = uoff - block_hdr;
		if (off[5:0] != 0) return;
		u = 10'(off >> MINC);
		if (!busy_head[u]) return;
		c = unit_cls[u];
		busy_head[u] = 1'b0;
		while (c < MAXC) begin
			size = longint'(1) << c;
			b = off ^ size;
			if (b < arena_hdr) break;
			if (b + size > seg) break;
			if ((b >> MINC) >= UNITS) break;
			bu = 10'(b >> MINC);
			if (!free_head[bu] || unit_cls[bu] != c) break;
			unlink_free(bu);
			free_head[bu] = 1'b0;
			c++;
			off &= ~((longint'(1) << c) - 1);
		end
		release_block(10'(off >> MINC), c);
	endfunction

	function automatic result_t predict_op(logic [1:0] kind, logic [15:0] req,
			logic [15:0] uoff);
		result_t r;
		r = '0;
		case (kind)
			KIND_ALLOC: r = carve_block(req);
			KIND_FREE: return_block(uoff);
			KIND_FORMAT: lay_out_arena();
			default: ;
		endcase
		return r;
	endfunction

	// hand one op word to the block; valid stays high for a following word
	task automatic send_op(logic [1:0] kind, logic [15:0] req, logic [15:0] uoff,
			bit typed, result_t typed_res);
		result_t r;
		if (!calm && $urandom_range(0, 99) < 16) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= kind;
		s_axis_tdata <= {uoff, req};
		do @(posedge clk); while (!s_axis_tready);
		r = predict_op(kind, req, uoff);
		if (kind == KIND_ALLOC && r.status == ST_OK) begin
			live_blocks.push_back(r.offset);
			last_block = r.offset;
		end
		if (kind == KIND_FORMAT) live_blocks.delete();
		pending_results.push_back(typed ? typed_res : r);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	// all three registers in one burst, block idle
	task automatic write_regs(bit [16:0] seg, bit [14:0] ahdr, bit [5:0] bhdr);
		bit [16:0] vals [3];
		vals = '{seg, 17'(ahdr), 17'(bhdr)};
		for (int i = 0; i < 3; i++) begin
			cfg_valid <= 1'b1;
			cfg_addr <= 2'(i);
			cfg_data <= vals[i];
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid <= 1'b0;
		seg_bytes = seg;
		arena_hdr = ahdr;
		block_hdr = bhdr;
	endtask

	// result checker and receiver stalls
	always @(posedge clk) begin
		result_t want;
		result_t got;
		if (m_axis_tvalid && m_axis_tready) begin
			got = {m_axis_tdata[1:0], m_axis_tdata[17:2]};
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result word: status %0d offset %0d",
						got.status, got.offset);
			end else begin
				want = pending_results.pop_front();
				if (want.status !== got.status || want.offset !== got.offset) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result mismatch: expected status %0d offset %0d, got status %0d offset %0d",
							want.status, want.offset, got.status, got.offset);
				end
			end
		end
		m_axis_tready <= calm || ($urandom_range(0, 99) >= 16);
	end

	// watchdog on cycles without any accepted word
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("buddy_block_allocator_core verification failed");
			$finish;
		end
	end

	// directed table: kind, request, offset in, free last block, typed check, status, offset
	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] req;
		logic [15:0] uoff;
		bit          free_last;
		bit          typed;
		logic [1:0]  status;
		logic [15:0] offset;
	} row_t;

	localparam int NROWS = 23;
	localparam row_t DIRECTED [NROWS] = '{
		'{KIND_ALLOC,  16'd100,   16'd0,     1'b0, 1'b1, ST_NO_SPACE,  16'd0}, // nothing laid out yet
		'{KIND_FREE,   16'd0,     16'd0,     1'b0, 1'b1, ST_OK,        16'd0},
		'{2'd3,        16'hffff,  16'hffff,  1'b0, 1'b1, ST_OK,        16'd0}, // unknown kind
		'{KIND_FORMAT, 16'd0,     16'd0,     1'b0, 1'b1, ST_OK,        16'd0},
		'{KIND_ALLOC,  16'd0,     16'd0,     1'b0, 1'b0, ST_OK,        16'd0}, // zero request
		'{KIND_ALLOC,  16'hffff,  16'd0,     1'b0, 1'b1, ST_TOO_LARGE, 16'd0},
		'{KIND_ALLOC,  16'd65528, 16'd0,     1'b0, 1'b1, ST_NO_SPACE,  16'd0}, // top class empty
		'{KIND_ALLOC,  16'd32760, 16'd0,     1'b0, 1'b0, ST_OK,        16'd0},
		'{KIND_ALLOC,  16'd32760, 16'd0,     1'b0, 1'b1, ST_NO_SPACE,  16'd0},
		'{KIND_FREE,   16'd0,     16'd0,     1'b1, 1'b0, ST_OK,        16'd0},
		'{KIND_FREE,   16'd0,     16'd0,     1'b1, 1'b1, ST_OK,        16'd0}, // double free
		'{KIND_ALLOC,  16'd56,    16'd0,     1'b0, 1'b0, ST_OK,        16'd0},
		'{KIND_FREE,   16'd0,     16'd0,     1'b1, 1'b0, ST_OK,        16'd0}, // merges back up
		'{KIND_FREE,   16'd0,     16'd3,     1'b0, 1'b1, ST_OK,        16'd0}, // below header
		'{KIND_FREE,   16'd0,     16'd1025,  1'b0, 1'b1, ST_OK,        16'd0}, // unaligned
		'{KIND_FREE,   16'd0,     16'hffff,  1'b0, 1'b1, ST_OK,        16'd0},
		'{KIND_FREE,   16'd0,     16'd8,     1'b0, 1'b1, ST_OK,        16'd0}, // not a block head
		'{KIND_ALLOC,  16'd1,     16'd0,     1'b0, 1'b0, ST_OK,        16'd0},
		'{KIND_ALLOC,  16'd1000,  16'd0,     1'b0, 1'b0, ST_OK,        16'd0},
		'{KIND_ALLOC,  16'd16376, 16'd0,     1'b0, 1'b0, ST_OK,        16'd0},
		'{KIND_FREE,   16'd0,     16'd0,     1'b1, 1'b0, ST_OK,        16'd0},
		'{KIND_FORMAT, 16'd0,     16'd0,     1'b0, 1'b1, ST_OK,        16'd0},
		'{KIND_ALLOC,  16'd200,   16'd0,     1'b0, 1'b0, ST_OK,        16'd0}
	};

	initial begin
		result_t   typed_res;
		logic [15:0] req;
		logic [15:0] uoff;
		int        pick;
		int        idx;
		bit [16:0] seg;
		bit [14:0] ahdr;
		bit [5:0]  bhdr;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part on the reset register values
		for (int i = 0; i < NROWS; i++) begin
			typed_res = {DIRECTED[i].status, DIRECTED[i].offset};
			uoff = DIRECTED[i].free_last ? last_block : DIRECTED[i].uoff;
			send_op(DIRECTED[i].kind, DIRECTED[i].req, uoff, DIRECTED[i].typed, typed_res);
		end
		drain();

		// random phases, each with its own register setting and a fresh format
		for (int ph = 0; ph < 7; ph++) begin
			case (ph)
				0: begin seg = 17'd64;     ahdr = 15'd16384; bhdr = 6'd63; end // nothing fits
				1: begin seg = 17'd65536;  ahdr = 15'd1;     bhdr = 6'd0;  end
				2: begin seg = 17'h1ffff;  ahdr = 15'd1;     bhdr = 6'd63; end // oversized
				3: begin seg = 17'($urandom_range(64, 4096)); ahdr = 15'($urandom_range(0, 255));
					bhdr = 6'($urandom); end
				4: begin seg = 17'($urandom); ahdr = 15'($urandom); bhdr = 6'($urandom); end
				default: begin
					seg = 17'($urandom_range(64, 65536));
					ahdr = 15'($urandom_range(1, 2048));
					bhdr = 6'($urandom);
				end
			endcase
			calm = (ph == 2);
			write_regs(seg, ahdr, bhdr);
			send_op(KIND_FORMAT, 16'($urandom), 16'($urandom), 1'b0, '0);
			for (int n = 0; n < 92; n++) begin
				pick = $urandom_range(0, 99);
				if (pick < 88 && pick >= 50 && live_blocks.size() != 0) begin
					idx = $urandom_range(0, live_blocks.size() - 1);
					uoff = live_blocks[idx];
					live_blocks.delete(idx);
					send_op(KIND_FREE, 16'($urandom), uoff, 1'b0, '0);
				end else if (pick >= 88 && pick < 92) begin
					send_op(KIND_FREE, 16'($urandom), 16'($urandom), 1'b0, '0);
				end else if (pick >= 92 && pick < 95) begin
					send_op(2'd3, 16'($urandom), 16'($urandom), 1'b0, '0);
				end else if (pick >= 95 && pick < 97) begin
					send_op(KIND_FORMAT, 16'($urandom), 16'($urandom), 1'b0, '0);
				end else begin
					idx = $urandom_range(0, 99);
					if (idx < 70) req = 16'($urandom_range(0, 300));
					else if (idx < 92) req = 16'($urandom_range(0, 4095));
					else req = 16'($urandom);
					send_op(KIND_ALLOC, req, 16'($urandom), 1'b0, '0);
				end
			end
			drain();
		end

		calm = 1'b0;
		repeat (40) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("buddy_block_allocator_core verification clean");
		else
			$display("buddy_block_allocator_core verification failed");
		$finish;
	end

endmodule
